// ----- rtl/cpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_pkg
// Types and constants shared by the colour map interpolator.
// ----------------------------------------------------------------------------
package cpi_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int CHAN_W    = 8;
	localparam int RGB_W     = 24;
	localparam int STOP_REGS = 5;
	localparam int DIV_W     = 16;
	localparam int T_W       = 19;
	localparam int SEG_W     = 3;
	localparam int IDX_W     = 3;
	localparam int X_W       = 24;
	localparam int NUM_CH    = 3;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [IDX_W-1:0] REG_LOW_BOUND  = 3'd0;
	localparam logic [IDX_W-1:0] REG_HIGH_BOUND = 3'd1;
	localparam logic [IDX_W-1:0] REG_STOP_0     = 3'd2;

	localparam logic signed [SAMPLE_W-1:0] LOW_RESET  = 16'sd0;
	localparam logic signed [SAMPLE_W-1:0] HIGH_RESET = 16'sd32767;
	localparam logic [STOP_REGS-1:0][RGB_W-1:0] STOP_RESET = {
		24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0]        low_bound;
		logic signed [SAMPLE_W-1:0]        high_bound;
		logic [STOP_REGS-1:0][RGB_W-1:0]   stop_color;
	} cfg_t;

	typedef struct packed {
		logic             below;
		logic             above;
		logic [T_W-1:0]   rem;
		logic [SEG_W-1:0] seg;
	} seg_t;

	typedef struct packed {
		logic                          below;
		logic                          above;
		logic [NUM_CH-1:0][X_W-1:0]    rem;
		logic [NUM_CH-1:0][CHAN_W-1:0] quo;
		logic [NUM_CH-1:0]             neg;
		logic [NUM_CH-1:0][CHAN_W-1:0] base;
	} lerp_t;

endpackage

// ----- rtl/cpi_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_sample_if
// Sample request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpi_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cpi_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ----- rtl/cpi_color_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_color_if
// RGB result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpi_color_if;
	logic                        valid;
	logic                        ready;
	logic [cpi_pkg::CHAN_W-1:0]  red;
	logic [cpi_pkg::CHAN_W-1:0]  green;
	logic [cpi_pkg::CHAN_W-1:0]  blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/cpi_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_cfg_regs
// APB register file holding the bounds and the colour stops.
// ----------------------------------------------------------------------------
module cpi_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cpi_pkg::ADDR_W-1:0]   paddr,
	input  logic [cpi_pkg::DATA_W-1:0]   pwdata,
	output logic [cpi_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output cpi_pkg::cfg_t                cfg
);

	logic [cpi_pkg::IDX_W-1:0] idx;
	logic [cpi_pkg::IDX_W-1:0] stop_idx;
	logic                      wr_en;
	logic                      is_stop;
	cpi_pkg::cfg_t             cfg_q;

	assign idx      = paddr[cpi_pkg::ADDR_W-1:2];
	assign stop_idx = idx - cpi_pkg::REG_STOP_0;
	assign is_stop  = (idx >= cpi_pkg::REG_STOP_0) &&
	                  (stop_idx < cpi_pkg::IDX_W'(cpi_pkg::STOP_REGS));
	assign wr_en    = psel & penable & pwrite;
	assign pready   = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_bound  <= cpi_pkg::LOW_RESET;
			cfg_q.high_bound <= cpi_pkg::HIGH_RESET;
			cfg_q.stop_color <= cpi_pkg::STOP_RESET;
		end else if (wr_en) begin
			priority if (idx == cpi_pkg::REG_LOW_BOUND) begin
				cfg_q.low_bound <= pwdata[cpi_pkg::SAMPLE_W-1:0];
			end else if (idx == cpi_pkg::REG_HIGH_BOUND) begin
				cfg_q.high_bound <= pwdata[cpi_pkg::SAMPLE_W-1:0];
			end else if (is_stop) begin
				cfg_q.stop_color[stop_idx] <= pwdata[cpi_pkg::RGB_W-1:0];
			end else begin
				cfg_q.low_bound <= cfg_q.low_bound;
			end
		end
	end

	always_comb begin
		prdata = '0;
		priority if (idx == cpi_pkg::REG_LOW_BOUND) begin
			prdata = cpi_pkg::DATA_W'(unsigned'(cfg_q.low_bound));
		end else if (idx == cpi_pkg::REG_HIGH_BOUND) begin
			prdata = cpi_pkg::DATA_W'(unsigned'(cfg_q.high_bound));
		end else if (is_stop) begin
			prdata = cpi_pkg::DATA_W'(cfg_q.stop_color[stop_idx]);
		end else begin
			prdata = '0;
		end
	end

endmodule

// ----- rtl/cpi_seg_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_seg_cell
// One restoring division step of the segment quotient, with its own stage.
// ----------------------------------------------------------------------------
module cpi_seg_cell #(
	parameter int SHIFT = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cpi_pkg::seg_t               in_data,
	input  logic [cpi_pkg::DIV_W-1:0]   divisor,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cpi_pkg::seg_t               out_data
);

	logic [cpi_pkg::T_W:0] dsh;
	logic [cpi_pkg::T_W:0] rem_ext;
	logic                  fits;
	cpi_pkg::seg_t         nxt;
	cpi_pkg::seg_t         data_q;
	logic                  valid_q;

	assign dsh      = (cpi_pkg::T_W + 1)'(divisor) << SHIFT;
	assign rem_ext  = (cpi_pkg::T_W + 1)'(in_data.rem);
	assign fits     = rem_ext >= dsh;
	assign in_ready = ~valid_q | out_ready;

	always_comb begin
		nxt = in_data;
		if (fits) begin
			nxt.rem        = cpi_pkg::T_W'(rem_ext - dsh);
			nxt.seg[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ----- rtl/cpi_lerp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_lerp_cell
// One restoring division step of the blend weight, all channels side by side.
// ----------------------------------------------------------------------------
module cpi_lerp_cell #(
	parameter int SHIFT = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cpi_pkg::lerp_t              in_data,
	input  logic [cpi_pkg::DIV_W-1:0]   divisor,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cpi_pkg::lerp_t              out_data
);

	logic [cpi_pkg::X_W:0] dsh;
	cpi_pkg::lerp_t        nxt;
	cpi_pkg::lerp_t        data_q;
	logic                  valid_q;

	assign dsh      = (cpi_pkg::X_W + 1)'(divisor) << SHIFT;
	assign in_ready = ~valid_q | out_ready;

	always_comb begin
		nxt = in_data;
		for (int c = 0; c < cpi_pkg::NUM_CH; c++) begin
			if ((cpi_pkg::X_W + 1)'(in_data.rem[c]) >= dsh) begin
				nxt.rem[c]        = cpi_pkg::X_W'((cpi_pkg::X_W + 1)'(in_data.rem[c]) - dsh);
				nxt.quo[c][SHIFT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ----- rtl/colormap_piecewise_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_piecewise_interpolator
// Maps a signed sample onto a false-colour RGB triple between colour stops.
// ----------------------------------------------------------------------------
// pipeline of bound check, 3 segment cells, stop select, multiply,
// 8 blend cells and the output register
// throughput one request per cycle, each cell stalls only when full
// reset clears all stage valid flags and loads the jet stops and bounds
module colormap_piecewise_interpolator #(
	parameter int NUM_STOPS = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	cpi_sample_if.sink                   samples,
	cpi_color_if.source                  colors,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cpi_pkg::ADDR_W-1:0]   paddr,
	input  logic [cpi_pkg::DATA_W-1:0]   pwdata,
	output logic [cpi_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam int LERP_CELLS = cpi_pkg::CHAN_W;
	localparam logic [cpi_pkg::IDX_W-1:0] LAST_IDX = cpi_pkg::IDX_W'(NUM_STOPS - 1);
	localparam logic [cpi_pkg::T_W-1:0]   SEG_MUL  = cpi_pkg::T_W'(NUM_STOPS - 1);

	function automatic logic [cpi_pkg::RGB_W-1:0] stop_at(
		input cpi_pkg::cfg_t c,
		input logic [cpi_pkg::IDX_W-1:0] i
	);
		logic [cpi_pkg::RGB_W-1:0] v;
		v = '0;
		if (i < cpi_pkg::IDX_W'(cpi_pkg::STOP_REGS)) begin
			v = c.stop_color[i];
		end
		return v;
	endfunction

	cpi_pkg::cfg_t              cfg;
	logic [cpi_pkg::DIV_W-1:0]  span;
	logic [cpi_pkg::DIV_W-1:0]  offset;

	cpi_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign span   = cpi_pkg::DIV_W'(cfg.high_bound - cfg.low_bound);
	assign offset = cpi_pkg::DIV_W'(samples.sample - cfg.low_bound);

	// bound check and scaled offset
	logic                 valid_s1;
	cpi_pkg::seg_t        data_s1;
	logic [cpi_pkg::SEG_W:0] seg_valid;
	logic [cpi_pkg::SEG_W:0] seg_ready;
	cpi_pkg::seg_t        seg_data [cpi_pkg::SEG_W+1];

	assign samples.ready = ~valid_s1 | seg_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			data_s1.below <= $signed(samples.sample) <= $signed(cfg.low_bound);
			data_s1.above <= $signed(samples.sample) >= $signed(cfg.high_bound);
			data_s1.rem   <= cpi_pkg::T_W'(offset) * SEG_MUL;
			data_s1.seg   <= '0;
		end
	end

	assign seg_valid[0] = valid_s1;
	assign seg_data[0]  = data_s1;

	// segment quotient, most significant step first
	for (genvar k = 0; k < cpi_pkg::SEG_W; k++) begin : g_seg
		cpi_seg_cell #(
			.SHIFT (cpi_pkg::SEG_W - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (seg_valid[k]),
			.in_ready  (seg_ready[k]),
			.in_data   (seg_data[k]),
			.divisor   (span),
			.out_valid (seg_valid[k+1]),
			.out_ready (seg_ready[k+1]),
			.out_data  (seg_data[k+1])
		);
	end

	// stop select
	logic                        valid_s2;
	logic                        below_s2;
	logic                        above_s2;
	logic [cpi_pkg::DIV_W-1:0]   frac_s2;
	logic [cpi_pkg::RGB_W-1:0]   ca_s2;
	logic [cpi_pkg::RGB_W-1:0]   cb_s2;
	logic                        ready_s2;
	logic [cpi_pkg::IDX_W-1:0]   seg_lo;
	logic [cpi_pkg::IDX_W-1:0]   seg_hi;

	assign seg_lo = (seg_data[cpi_pkg::SEG_W].seg > LAST_IDX - 1'b1) ?
	                LAST_IDX - 1'b1 : seg_data[cpi_pkg::SEG_W].seg;
	assign seg_hi = seg_lo + 1'b1;
	assign seg_ready[cpi_pkg::SEG_W] = ~valid_s2 | ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (seg_ready[cpi_pkg::SEG_W]) begin
			valid_s2 <= seg_valid[cpi_pkg::SEG_W];
		end
	end

	always_ff @(posedge clk) begin
		if (seg_ready[cpi_pkg::SEG_W] && seg_valid[cpi_pkg::SEG_W]) begin
			below_s2 <= seg_data[cpi_pkg::SEG_W].below;
			above_s2 <= seg_data[cpi_pkg::SEG_W].above;
			frac_s2  <= seg_data[cpi_pkg::SEG_W].rem[cpi_pkg::DIV_W-1:0];
			ca_s2    <= stop_at(cfg, seg_lo);
			cb_s2    <= stop_at(cfg, seg_hi);
		end
	end

	// channel differences times fraction
	logic                    valid_s3;
	cpi_pkg::lerp_t          data_s3;
	cpi_pkg::lerp_t          mul_nxt;
	logic [LERP_CELLS:0]     lerp_valid;
	logic [LERP_CELLS:0]     lerp_ready;
	cpi_pkg::lerp_t          lerp_data [LERP_CELLS+1];

	assign ready_s2 = ~valid_s3 | lerp_ready[0];

	always_comb begin
		logic [cpi_pkg::CHAN_W-1:0] a;
		logic [cpi_pkg::CHAN_W-1:0] b;
		logic [cpi_pkg::CHAN_W-1:0] mag;
		mul_nxt       = '0;
		mul_nxt.below = below_s2;
		mul_nxt.above = above_s2;
		for (int c = 0; c < cpi_pkg::NUM_CH; c++) begin
			a   = ca_s2[cpi_pkg::RGB_W-1-cpi_pkg::CHAN_W*c -: cpi_pkg::CHAN_W];
			b   = cb_s2[cpi_pkg::RGB_W-1-cpi_pkg::CHAN_W*c -: cpi_pkg::CHAN_W];
			mag = (b >= a) ? b - a : a - b;
			mul_nxt.neg[c]  = b < a;
			mul_nxt.base[c] = a;
			mul_nxt.rem[c]  = cpi_pkg::X_W'(mag) * cpi_pkg::X_W'(frac_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			data_s3 <= mul_nxt;
		end
	end

	assign lerp_valid[0] = valid_s3;
	assign lerp_data[0]  = data_s3;

	// blend weight quotient, most significant step first
	for (genvar k = 0; k < LERP_CELLS; k++) begin : g_lerp
		cpi_lerp_cell #(
			.SHIFT (LERP_CELLS - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (lerp_valid[k]),
			.in_ready  (lerp_ready[k]),
			.in_data   (lerp_data[k]),
			.divisor   (span),
			.out_valid (lerp_valid[k+1]),
			.out_ready (lerp_ready[k+1]),
			.out_data  (lerp_data[k+1])
		);
	end

	// rounding, blend and end-stop override
	logic                                       valid_s4;
	logic [cpi_pkg::NUM_CH-1:0][cpi_pkg::CHAN_W-1:0] rgb_s4;
	logic [cpi_pkg::NUM_CH-1:0][cpi_pkg::CHAN_W-1:0] rgb_nxt;
	cpi_pkg::lerp_t                             fin;
	logic [cpi_pkg::RGB_W-1:0]                  first_stop;
	logic [cpi_pkg::RGB_W-1:0]                  last_stop;

	assign fin        = lerp_data[LERP_CELLS];
	assign first_stop = stop_at(cfg, '0);
	assign last_stop  = stop_at(cfg, LAST_IDX);
	assign lerp_ready[LERP_CELLS] = ~valid_s4 | colors.ready;

	always_comb begin
		logic                         rnd;
		logic [cpi_pkg::CHAN_W-1:0]   q;
		for (int c = 0; c < cpi_pkg::NUM_CH; c++) begin
			rnd = {fin.rem[c][cpi_pkg::DIV_W-1:0], 1'b0} >= {1'b0, span};
			q   = fin.quo[c] + cpi_pkg::CHAN_W'(rnd);
			if (fin.below) begin
				rgb_nxt[c] = first_stop[cpi_pkg::RGB_W-1-cpi_pkg::CHAN_W*c -: cpi_pkg::CHAN_W];
			end else if (fin.above) begin
				rgb_nxt[c] = last_stop[cpi_pkg::RGB_W-1-cpi_pkg::CHAN_W*c -: cpi_pkg::CHAN_W];
			end else if (fin.neg[c]) begin
				rgb_nxt[c] = fin.base[c] - q;
			end else begin
				rgb_nxt[c] = fin.base[c] + q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (lerp_ready[LERP_CELLS]) begin
			valid_s4 <= lerp_valid[LERP_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (lerp_ready[LERP_CELLS] && lerp_valid[LERP_CELLS]) begin
			rgb_s4 <= rgb_nxt;
		end
	end

	assign colors.valid = valid_s4;
	assign colors.red   = rgb_s4[0];
	assign colors.green = rgb_s4[1];
	assign colors.blue  = rgb_s4[2];

endmodule

// ----- verif/colormap_piecewise_interpolator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_piecewise_interpolator_tb
// Self-checking bench for the false-colour interpolator. A clocked driver feeds
// sample requests from a queue and a clocked monitor compares every colour
// against a bit-exact predictor of the piecewise blend, under bound and stop
// settings programmed over the register port while the pipeline is empty.
// ----------------------------------------------------------------------------
module colormap_piecewise_interpolator_tb;

	localparam int NUM_STOPS = 5;
	localparam int PIPE_GAP  = 20;
	localparam logic [cpi_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [cpi_pkg::ADDR_W-1:0]   paddr;
	logic [cpi_pkg::DATA_W-1:0]   pwdata;
	logic [cpi_pkg::DATA_W-1:0]   prdata;
	logic                         pready;

	cpi_sample_if sample_ch ();
	cpi_color_if  color_ch ();

	colormap_piecewise_interpolator #(
		.NUM_STOPS(NUM_STOPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sample_ch),
		.colors(color_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	cpi_pkg::cfg_t                   shadow;
	logic [cpi_pkg::SAMPLE_W-1:0]    sample_queue [$];
	logic [cpi_pkg::RGB_W-1:0]       expected_colors [$];
	logic [cpi_pkg::RGB_W-1:0]       want_rgb;
	bit                              quiet;
	bit                              hold_send;
	int                              error_count;
	int                              accepted_count;
	int                              checked_count;
	int                              setting_count;

	always #5 clk = ~clk;

	function automatic logic [cpi_pkg::RGB_W-1:0] stop_rgb(input int i);
		if (i >= 0 && i < cpi_pkg::STOP_REGS)
			return shadow.stop_color[i];
		return '0;
	endfunction

	// a + round((b - a) * rem / d), halves away from zero
	function automatic logic [cpi_pkg::CHAN_W-1:0] blend_channel(input int a, input int b,
		input int rem, input int d);
		int     diff;
		int     res;
		longint mag;
		longint q;
		diff = b - a;
		mag = (diff < 0) ? -diff : diff;
		q = (2 * mag * rem + d) / (2 * longint'(d));
		res = (diff < 0) ? a - int'(q) : a + int'(q);
		if (res < 0)
			res = 0;
		if (res > 255)
			res = 255;
		return res[cpi_pkg::CHAN_W-1:0];
	endfunction

	function automatic logic [cpi_pkg::RGB_W-1:0] map_sample(
		input logic signed [cpi_pkg::SAMPLE_W-1:0] s);
		int                          v;
		int                          lo;
		int                          hi;
		int                          d;
		int                          t;
		int                          seg;
		int                          rem;
		logic [cpi_pkg::RGB_W-1:0]   ca;
		logic [cpi_pkg::RGB_W-1:0]   cb;
		logic [cpi_pkg::RGB_W-1:0]   rgb;
		v = s;
		lo = shadow.low_bound;
		hi = shadow.high_bound;
		if (v <= lo)
			return stop_rgb(0);
		if (v >= hi)
			return stop_rgb(NUM_STOPS - 1);
		d = hi - lo;
		t = (v - lo) * (NUM_STOPS - 1);
		seg = t / d;
		rem = t % d;
		if (seg > NUM_STOPS - 2)
			seg = NUM_STOPS - 2;
		ca = stop_rgb(seg);
		cb = stop_rgb(seg + 1);
		for (int k = 0; k < cpi_pkg::NUM_CH; k++)
			rgb[cpi_pkg::CHAN_W*k +: cpi_pkg::CHAN_W] =
				blend_channel(ca[cpi_pkg::CHAN_W*k +: cpi_pkg::CHAN_W],
				cb[cpi_pkg::CHAN_W*k +: cpi_pkg::CHAN_W], rem, d);
		return rgb;
	endfunction

	// mostly inside the bounds, some near them, some anywhere; with equal or reversed bounds, half near low, half anywhere
	function automatic logic [cpi_pkg::SAMPLE_W-1:0] pick_sample();
		int lo;
		int hi;
		int roll;
		lo = shadow.low_bound;
		hi = shadow.high_bound;
		roll = $urandom_range(0, 99);
		if (hi <= lo) begin
			if (roll < 50)
				return cpi_pkg::SAMPLE_W'(lo + int'($urandom_range(0, 4)) - 2);
			return cpi_pkg::SAMPLE_W'($urandom);
		end
		if (roll < 12)
			return cpi_pkg::SAMPLE_W'($urandom);
		if (roll < 20)
			return cpi_pkg::SAMPLE_W'((roll[0] ? lo : hi) + int'($urandom_range(0, 2)) - 1);
		return cpi_pkg::SAMPLE_W'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < 50)
			$display("%0t ns: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic write_reg(input logic [cpi_pkg::IDX_W-1:0] idx,
		input logic [cpi_pkg::DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == cpi_pkg::REG_LOW_BOUND)
			shadow.low_bound = value[cpi_pkg::SAMPLE_W-1:0];
		else if (idx == cpi_pkg::REG_HIGH_BOUND)
			shadow.high_bound = value[cpi_pkg::SAMPLE_W-1:0];
		else if (idx >= cpi_pkg::REG_STOP_0 &&
			idx < cpi_pkg::REG_STOP_0 + cpi_pkg::STOP_REGS)
			shadow.stop_color[idx - cpi_pkg::REG_STOP_0] = value[cpi_pkg::RGB_W-1:0];
	endtask

	// upper bits carry junk, the registers keep only their own width
	task automatic configure(input int lo, input int hi,
		input logic [cpi_pkg::STOP_REGS-1:0][cpi_pkg::RGB_W-1:0] stops);
		write_reg(cpi_pkg::REG_LOW_BOUND, {16'($urandom), 16'(lo)});
		write_reg(cpi_pkg::REG_HIGH_BOUND, {16'($urandom), 16'(hi)});
		for (int i = 0; i < cpi_pkg::STOP_REGS; i++)
			write_reg(cpi_pkg::REG_STOP_0 + cpi_pkg::IDX_W'(i), {8'($urandom), stops[i]});
		setting_count++;
	endtask

	task automatic drain();
		while (sample_queue.size() != 0 || sample_ch.valid || expected_colors.size() != 0)
			@(posedge clk);
		repeat (PIPE_GAP) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.sample <= '0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_colors.push_back(map_sample(sample_ch.sample));
				accepted_count++;
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (sample_queue.size() != 0 && !hold_send &&
					(quiet || $urandom_range(0, 99) >= 14)) begin
					sample_ch.valid <= 1'b1;
					sample_ch.sample <= sample_queue.pop_front();
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// colour monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_ch.ready <= 1'b0;
		end else begin
			if (color_ch.valid && color_ch.ready) begin
				if (expected_colors.size() == 0) begin
					report_mismatch($sformatf("unexpected colour %02h %02h %02h",
						color_ch.red, color_ch.green, color_ch.blue));
				end else begin
					want_rgb = expected_colors.pop_front();
					if (color_ch.red !== want_rgb[23:16])
						report_mismatch($sformatf("result %0d red %02h, want %02h",
							checked_count, color_ch.red, want_rgb[23:16]));
					if (color_ch.green !== want_rgb[15:8])
						report_mismatch($sformatf("result %0d green %02h, want %02h",
							checked_count, color_ch.green, want_rgb[15:8]));
					if (color_ch.blue !== want_rgb[7:0])
						report_mismatch($sformatf("result %0d blue %02h, want %02h",
							checked_count, color_ch.blue, want_rgb[7:0]));
					checked_count++;
				end
			end
			color_ch.ready <= quiet || ($urandom_range(0, 99) >= 14);
		end
	end

	initial begin
		int                                                lo;
		int                                                hi;
		int                                                a;
		int                                                b;
		int                                                count;
		logic [cpi_pkg::STOP_REGS-1:0][cpi_pkg::RGB_W-1:0] stops;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		color_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		hold_send = 1'b0;
		shadow.low_bound = cpi_pkg::LOW_RESET;
		shadow.high_bound = cpi_pkg::HIGH_RESET;
		shadow.stop_color = cpi_pkg::STOP_RESET;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset stops: extremes and segment edges
		sample_queue = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'd8191, 16'd8192,
			16'd16383, 16'd16384, 16'd24575, 16'd24576, 16'd32766, 16'h7FFF};
		drain();

		// even span so exact halves round away from zero both ways
		configure(0, 8, {24'h000000, 24'hFFFFFF, 24'h123456, 24'hFF0001, 24'h00FF00});
		sample_queue = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd8, 16'd0, 16'h8000};
		drain();
		write_reg(REG_UNUSED, $urandom);
		sample_queue.push_back(16'd1);
		drain();

		// equal bounds, then reversed bounds
		configure(100, 100, {24'hA0B0C0, 24'h0, 24'h0, 24'h0, 24'h102030});
		sample_queue = '{16'd99, 16'd100, 16'd101};
		drain();
		configure(200, -200, {24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h000000});
		sample_queue = '{16'd0, 16'd300};
		drain();

		for (int p = 0; p < 8; p++) begin
			for (int i = 0; i < cpi_pkg::STOP_REGS; i++)
				stops[i] = cpi_pkg::RGB_W'($urandom);
			a = int'($urandom_range(0, 65535)) - 32768;
			b = int'($urandom_range(0, 65535)) - 32768;
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			count = 240;
			case (p)
				0: begin
					lo = -32768;
					hi = 32767;
				end
				1: begin
					lo = 32767;
					hi = -32768;
					count = 60;
				end
				2: begin
					lo = int'($urandom_range(0, 65000)) - 32768;
					hi = lo + int'($urandom_range(1, 16));
				end
				4: begin
					for (int i = 0; i < cpi_pkg::STOP_REGS; i++)
						stops[i] = i[0] ? 24'hFFFFFF : 24'h000000;
				end
				6: begin
					hi = lo;
					count = 120;
				end
				7: count = 300;
				default: ;
			endcase
			configure(lo, hi, stops);
			quiet = (p == 3);
			repeat (count) sample_queue.push_back(pick_sample());
			if (p == 5) begin
				while (sample_queue.size() > count / 2)
					@(posedge clk);
				hold_send = 1'b1;
				while (sample_ch.valid || expected_colors.size() != 0)
					@(posedge clk);
				hold_send = 1'b0;
			end
			drain();
			quiet = 1'b0;
		end

		repeat (PIPE_GAP) @(posedge clk);
		if (expected_colors.size() != 0)
			report_mismatch($sformatf("%0d colours never arrived", expected_colors.size()));
		$display("covered %0d samples over %0d bound and stop settings", accepted_count,
			setting_count);
		$display("full-range, narrow, equal and reversed bounds; %0d colours checked, %0d errors",
			checked_count, error_count);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/cpi_pkg.sv
rtl/cpi_sample_if.sv
rtl/cpi_color_if.sv
rtl/cpi_cfg_regs.sv
rtl/cpi_seg_cell.sv
rtl/cpi_lerp_cell.sv
rtl/colormap_piecewise_interpolator.sv
verif/colormap_piecewise_interpolator_tb.sv
